[hw/rtl/srma_pkg.sv]
// Shared types and codes for the sparse row merge-add block.
package srma_pkg;

    localparam int COL_W   = 16;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 33;
    localparam int ENTRY_W = COL_W + VAL_W;
    localparam int NUM_W   = 7;

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_MERGE  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_CMP   = 4'b0100,
        ST_FINAL = 4'b1000
    } state_t;

    typedef struct packed {
        logic                    take_a;
        logic                    take_b;
        logic                    emit;
        logic [COL_W-1:0]        col;
        logic signed [SUM_W-1:0] val;
    } step_t;

endpackage

[hw/rtl/srma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module srma_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/srma_step.sv]
// Shared compare and add unit: decides one merge step from the two head entries.
module srma_step (
    input  logic                                    a_live,
    input  logic                                    b_live,
    input  logic [srma_pkg::COL_W-1:0]              col_a,
    input  logic [srma_pkg::COL_W-1:0]              col_b,
    input  logic signed [srma_pkg::VAL_W-1:0]       val_a,
    input  logic signed [srma_pkg::VAL_W-1:0]       val_b,
    output srma_pkg::step_t                         step
);

    logic                                 a_lt;
    logic                                 b_lt;
    logic signed [srma_pkg::SUM_W-1:0]    sum;

    assign a_lt = col_a < col_b;
    assign b_lt = col_b < col_a;
    assign sum  = {val_a[srma_pkg::VAL_W-1], val_a} + {val_b[srma_pkg::VAL_W-1], val_b};

    always_comb
    begin
        step = '0;
        if (a_live && (!b_live || a_lt))
        begin
            step.take_a = 1'b1;
            step.emit   = 1'b1;
            step.col    = col_a;
            step.val    = {val_a[srma_pkg::VAL_W-1], val_a};
        end
        else if (b_live && (!a_live || b_lt))
        begin
            step.take_b = 1'b1;
            step.emit   = 1'b1;
            step.col    = col_b;
            step.val    = {val_b[srma_pkg::VAL_W-1], val_b};
        end
        else if (a_live && b_live)
        begin
            step.take_a = 1'b1;
            step.take_b = 1'b1;
            step.emit   = (sum != '0);
            step.col    = col_a;
            step.val    = sum;
        end
    end

endmodule

[hw/rtl/sparse_row_merge_add_top.sv]
// Top level of the sparse row merge-add block: load buffers, merge sequencer, output register.
//
// Loads (kind 0 or 1) each write one RAM entry while that buffer is not full;
// otherwise the entry is dropped and overflow is flagged. An end-of-row item starts
// the merge: every merge step is a registered RAM read of both head entries, then
// one pass through the shared compare/add unit, which waits on an output stall;
// there are at most first_count + second_count steps, and a read and a final state
// close the row. Input ready is high only while the sequencer is idle. Results go
// through one output register; the final item carries last_of_row and row_entry_count.
module sparse_row_merge_add_top #(
    parameter int ROW_CAPACITY = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic [srma_pkg::COL_W-1:0]          column,
    input  logic signed [srma_pkg::VAL_W-1:0]   entry_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [srma_pkg::COL_W-1:0]          out_column,
    output logic signed [srma_pkg::SUM_W-1:0]   out_value,
    output logic                                entry_valid,
    output logic                                last_of_row,
    output logic [srma_pkg::NUM_W-1:0]          row_entry_count,
    output logic                                overflow
);

    localparam int AW = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
    localparam int CW = $clog2(ROW_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(ROW_CAPACITY);

    srma_pkg::state_t state_reg, state_next;

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [srma_pkg::NUM_W-1:0] n_reg, n_next;
    logic          held_v_reg, held_v_next;
    logic [srma_pkg::COL_W-1:0]        held_col_reg;
    logic signed [srma_pkg::SUM_W-1:0] held_val_reg;
    logic          out_valid_reg;

    logic [srma_pkg::COL_W-1:0]        out_column_reg;
    logic signed [srma_pkg::SUM_W-1:0] out_value_reg;
    logic          entry_valid_reg;
    logic          last_reg;
    logic [srma_pkg::NUM_W-1:0] count_reg;
    logic          overflow_reg;

    logic          load_a, load_b;
    logic          accept;
    logic          a_live, b_live;
    logic          can_push;
    logic          push;
    logic          push_last;
    logic          take_held;
    logic [srma_pkg::ENTRY_W-1:0] wr_data;
    logic [srma_pkg::ENTRY_W-1:0] rd_a, rd_b;
    srma_pkg::step_t step;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == srma_pkg::ST_IDLE);
    assign load_a   = accept && (kind == srma_pkg::KIND_FIRST) && (first_count_reg < CAP);
    assign load_b   = accept && (kind == srma_pkg::KIND_SECOND) && (second_count_reg < CAP);
    assign wr_data  = {column, entry_value};
    assign a_live   = a_reg < first_count_reg;
    assign b_live   = b_reg < second_count_reg;
    assign can_push = !out_valid_reg || out_ready;

    srma_ram #(.WIDTH(srma_pkg::ENTRY_W), .DEPTH(ROW_CAPACITY)) u_first_ram (
        .clk     (clk),
        .wr_en   (load_a),
        .wr_addr (first_count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (a_reg[AW-1:0]),
        .rd_data (rd_a)
    );

    srma_ram #(.WIDTH(srma_pkg::ENTRY_W), .DEPTH(ROW_CAPACITY)) u_second_ram (
        .clk     (clk),
        .wr_en   (load_b),
        .wr_addr (second_count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (b_reg[AW-1:0]),
        .rd_data (rd_b)
    );

    srma_step u_step (
        .a_live (a_live),
        .b_live (b_live),
        .col_a  (rd_a[srma_pkg::ENTRY_W-1:srma_pkg::VAL_W]),
        .col_b  (rd_b[srma_pkg::ENTRY_W-1:srma_pkg::VAL_W]),
        .val_a  (rd_a[srma_pkg::VAL_W-1:0]),
        .val_b  (rd_b[srma_pkg::VAL_W-1:0]),
        .step   (step)
    );

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        a_next            = a_reg;
        b_next            = b_reg;
        n_next            = n_reg;
        held_v_next       = held_v_reg;
        push              = 1'b0;
        push_last         = 1'b0;
        take_held         = 1'b0;
        case (state_reg)
            srma_pkg::ST_IDLE:
            begin
                if (load_a)
                begin
                    first_count_next = first_count_reg + 1'b1;
                end
                if (load_b)
                begin
                    second_count_next = second_count_reg + 1'b1;
                end
                if (accept && ((kind == srma_pkg::KIND_FIRST && !load_a)
                               || (kind == srma_pkg::KIND_SECOND && !load_b)))
                begin
                    dropped_next = 1'b1;
                end
                if (accept && kind == srma_pkg::KIND_MERGE)
                begin
                    a_next      = '0;
                    b_next      = '0;
                    n_next      = '0;
                    held_v_next = 1'b0;
                    state_next  = srma_pkg::ST_READ;
                end
            end
            srma_pkg::ST_READ:
            begin
                if (a_live || b_live)
                begin
                    state_next = srma_pkg::ST_CMP;
                end
                else
                begin
                    state_next = srma_pkg::ST_FINAL;
                end
            end
            srma_pkg::ST_CMP:
            begin
                if (!(step.emit && held_v_reg) || can_push)
                begin
                    push   = step.emit && held_v_reg;
                    a_next = a_reg + CW'(step.take_a);
                    b_next = b_reg + CW'(step.take_b);
                    if (step.emit)
                    begin
                        held_v_next = 1'b1;
                        take_held   = 1'b1;
                        n_next      = n_reg + 1'b1;
                    end
                    state_next = srma_pkg::ST_READ;
                end
            end
            srma_pkg::ST_FINAL:
            begin
                if (can_push)
                begin
                    push              = 1'b1;
                    push_last         = 1'b1;
                    first_count_next  = '0;
                    second_count_next = '0;
                    dropped_next      = 1'b0;
                    a_next            = '0;
                    b_next            = '0;
                    held_v_next       = 1'b0;
                    state_next        = srma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= srma_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
            a_reg            <= '0;
            b_reg            <= '0;
            n_reg            <= '0;
            held_v_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
            a_reg            <= a_next;
            b_reg            <= b_next;
            n_reg            <= n_next;
            held_v_reg       <= held_v_next;
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_held)
        begin
            held_col_reg <= step.col;
            held_val_reg <= step.val;
        end
        if (push)
        begin
            // an empty row sends one item with no entry
            out_column_reg  <= held_v_reg ? held_col_reg : '0;
            out_value_reg   <= held_v_reg ? held_val_reg : '0;
            entry_valid_reg <= held_v_reg;
            last_reg        <= push_last;
            count_reg       <= (push_last && held_v_reg) ? n_reg : '0;
            overflow_reg    <= dropped_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_column      = out_column_reg;
    assign out_value       = out_value_reg;
    assign entry_valid     = entry_valid_reg;
    assign last_of_row     = last_reg;
    assign row_entry_count = count_reg;
    assign overflow        = overflow_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (a_reg <= first_count_reg) && (b_reg <= second_count_reg))
        else $error("merge pointer ran past buffer fill");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srma_pkg::ST_FINAL && can_push)
        |=> (first_count_reg == '0 && second_count_reg == '0 && !dropped_reg))
        else $error("row state not cleared after merge");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != srma_pkg::ST_IDLE)
        |-> (n_reg <= srma_pkg::NUM_W'(a_reg) + srma_pkg::NUM_W'(b_reg)))
        else $error("emitted count exceeds consumed entries");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> can_push)
        else $error("result overwritten before transfer");

endmodule
